// ----- src/assert_macros.svh -----
// Assertion macros shared by the cache tag controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define SACTC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Implication checked in the cycle after the antecedent.
`define SACTC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- src/sactc_pkg.sv -----
// Package of shared types and constants for the cache tag controller.
package sactc_pkg;
  localparam int DEF_WAYS = 4;
  localparam int DEF_SETS = 64;
  localparam int DEF_OFFSET_BITS = 5;
  localparam int DEF_COUNTER_BITS = 16;
  localparam int ADDR_W = 32;
  localparam int SET_OUT_W = 6;
  localparam int WAY_OUT_W = 2;
  localparam int POLICY_W = 3;
  localparam int CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] REG_POLICY = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_HASH = 1'b1;
  localparam logic [POLICY_W-1:0] POL_FIFO = 3'd0;
  localparam logic [POLICY_W-1:0] POL_RANDOM = 3'd1;
  localparam logic [POLICY_W-1:0] POL_LRU = 3'd2;
  localparam logic [POLICY_W-1:0] POL_LFU = 3'd3;
  localparam logic [POLICY_W-1:0] POL_LRU_MRU = 3'd4;
  localparam logic [15:0] LFSR_SEED = 16'hACE1;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_LOOKUP, ST_PROMOTE, ST_WRITE, ST_OUT
  } state_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic rd;
    logic lookup;
    logic promote;
    logic wr;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
    logic clear_done;
  } status_t;
endpackage

// ----- src/sactc_ctrl.sv -----
// Controller state machine that sequences one request through the datapath.
module sactc_ctrl import sactc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t status,
  output cmd_t    cmd
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:   if (status.clear_done) state_nxt = ST_IDLE;
      ST_IDLE:    if (in_valid) state_nxt = ST_READ;
      ST_READ:    state_nxt = ST_LOOKUP;
      ST_LOOKUP:  state_nxt = ST_PROMOTE;
      ST_PROMOTE: state_nxt = ST_WRITE;
      ST_WRITE:   state_nxt = ST_OUT;
      ST_OUT:     if (!status.out_busy) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_CLEAR:   cmd.clear = 1'b1;
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_READ:    cmd.rd = 1'b1;
      ST_LOOKUP:  cmd.lookup = 1'b1;
      ST_PROMOTE: cmd.promote = 1'b1;
      ST_WRITE:   cmd.wr = 1'b1;
      ST_OUT:     cmd.out_load = !status.out_busy;
      default:    in_stall = 1'b1;
    endcase
  end
endmodule

// ----- src/sactc_dp.sv -----
// Datapath with tag, counter and state stores, victim selection and output register.
module sactc_dp import sactc_pkg::*; #(
  parameter int WAYS = DEF_WAYS,
  parameter int SETS = DEF_SETS,
  parameter int OFFSET_BITS = DEF_OFFSET_BITS,
  parameter int COUNTER_BITS = DEF_COUNTER_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output status_t               status,
  input  logic [ADDR_W-1:0]     in_address,
  input  logic                  in_op,
  input  logic [POLICY_W-1:0]   policy,
  input  logic                  hash_en,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_hit,
  output logic [SET_OUT_W-1:0]  out_set_index,
  output logic [WAY_OUT_W-1:0]  out_way,
  output logic                  out_writeback,
  output logic [ADDR_W-1:0]     out_writeback_address
);
  localparam int IB = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WB = $clog2(WAYS);
  localparam int SHIFT = OFFSET_BITS + IB;
  localparam int TAG_W = ADDR_W - SHIFT;
  localparam logic [COUNTER_BITS-1:0] CMAX = '1;

  typedef logic [COUNTER_BITS-1:0] cnt_t;

  logic [WAYS-1:0][TAG_W-1:0]        tag_mem [SETS];
  logic [WAYS-1:0][COUNTER_BITS-1:0] cnt_mem [SETS];
  logic [WAYS-1:0]  valid_r [SETS];
  logic [WAYS-1:0]  dirty_r [SETS];
  logic [WB-1:0]    fifo_r  [SETS];
  logic [15:0]      lfsr_r;
  logic [IB-1:0]    clr_r;

  logic [TAG_W-1:0] tag_r;
  logic             op_r;
  logic [IB-1:0]    set_r;
  logic [TAG_W-1:0] rtag_r [WAYS];
  cnt_t             rcnt_r [WAYS];
  logic [WAYS-1:0]  v_r, d_r;
  logic [WB-1:0]    f_r;
  logic             hit_r, wb_r;
  logic [WB-1:0]    way_r;
  logic [ADDR_W-1:0] wba_r;
  cnt_t             ncnt_r [WAYS];
  logic             cwr_r;

  logic [TAG_W-1:0] a_tag;
  logic [IB-1:0]    a_set;
  assign a_tag = in_address[ADDR_W-1:SHIFT];
  assign a_set = in_address[SHIFT-1:OFFSET_BITS] ^ {{(IB-1){1'b0}}, hash_en & a_tag[0]};

  // Lookup logic.
  logic          l_hit, l_free;
  logic [WB-1:0] l_hw, l_fw, l_mw, l_way, l_fifo;
  logic [15:0]   l_lfsr;
  always_comb begin
    l_hit = 1'b0; l_hw = '0; l_free = 1'b0; l_fw = '0; l_mw = '0;
    for (int j = WAYS-1; j >= 0; j--) begin
      if (v_r[j] && rtag_r[j] == tag_r) begin l_hit = 1'b1; l_hw = WB'(j); end
      if (!v_r[j]) begin l_free = 1'b1; l_fw = WB'(j); end
    end
    for (int j = 1; j < WAYS; j++) begin
      if (rcnt_r[j] < rcnt_r[l_mw]) l_mw = WB'(j);
    end
    l_fifo = f_r + 1'b1;
    l_lfsr = {lfsr_r[0] ^ lfsr_r[2] ^ lfsr_r[3] ^ lfsr_r[5], lfsr_r[15:1]};
    if (l_hit) l_way = l_hw;
    else if (l_free) l_way = l_fw;
    else if (policy == POL_FIFO) l_way = l_fifo;
    else if (policy == POL_RANDOM) l_way = l_lfsr[WB-1:0];
    else l_way = l_mw;
  end

  // Counter update logic.
  cnt_t p_cnt [WAYS];
  logic p_en;
  always_comb begin
    cnt_t top, low, nv;
    logic any;
    top = '0; low = '0; any = 1'b0;
    for (int j = 0; j < WAYS; j++) p_cnt[j] = rcnt_r[j];
    for (int j = 0; j < WAYS; j++) if (v_r[j] && rcnt_r[j] > top) top = rcnt_r[j];
    nv = (top == CMAX) ? CMAX : top + 1'b1;
    if (policy == POL_LFU) begin
      p_en = 1'b1;
      if (hit_r) p_cnt[way_r] = (rcnt_r[way_r] == CMAX) ? CMAX : rcnt_r[way_r] + 1'b1;
      else p_cnt[way_r] = cnt_t'(1);
    end else if (hit_r || policy == POL_LRU_MRU) begin
      p_en = 1'b1;
      p_cnt[way_r] = nv;
      for (int j = 0; j < WAYS; j++)
        if (v_r[j] && (!any || p_cnt[j] < low)) begin low = p_cnt[j]; any = 1'b1; end
      for (int j = 0; j < WAYS; j++)
        p_cnt[j] = !any ? '0 : (p_cnt[j] >= low ? p_cnt[j] - low : '0);
    end else begin
      p_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      valid_r[clr_r] <= '0;
      dirty_r[clr_r] <= '0;
      fifo_r[clr_r] <= '0;
      cnt_mem[clr_r] <= '0;
    end
    if (cmd.load) begin
      tag_r <= a_tag; op_r <= in_op; set_r <= a_set;
    end
    if (cmd.rd) begin
      for (int j = 0; j < WAYS; j++) begin
        rtag_r[j] <= tag_mem[set_r][j];
        rcnt_r[j] <= cnt_mem[set_r][j];
      end
      v_r <= valid_r[set_r];
      d_r <= dirty_r[set_r];
      f_r <= fifo_r[set_r];
    end
    if (cmd.lookup) begin
      hit_r <= l_hit;
      way_r <= l_way;
      wb_r  <= !l_hit && v_r[l_way] && d_r[l_way];
      wba_r <= {rtag_r[l_way], set_r ^ {{(IB-1){1'b0}}, hash_en & rtag_r[l_way][0]},
                OFFSET_BITS'(0)};
      if (!l_hit && !l_free && policy == POL_FIFO) fifo_r[set_r] <= l_fifo;
    end
    if (cmd.promote) begin
      for (int j = 0; j < WAYS; j++) ncnt_r[j] <= p_cnt[j];
      cwr_r <= p_en;
    end
    if (cmd.wr) begin
      if (cwr_r)
        for (int j = 0; j < WAYS; j++) cnt_mem[set_r][j] <= ncnt_r[j];
      if (!hit_r) tag_mem[set_r][way_r] <= tag_r;
      valid_r[set_r][way_r] <= 1'b1;
      if (op_r || !hit_r) dirty_r[set_r][way_r] <= op_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r <= LFSR_SEED;
      clr_r <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clear) clr_r <= clr_r + 1'b1;
      if (cmd.lookup && !l_hit && !l_free && policy == POL_RANDOM) lfsr_r <= l_lfsr;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_hit <= hit_r;
      out_set_index <= SET_OUT_W'(set_r);
      out_way <= WAY_OUT_W'(way_r);
      out_writeback <= wb_r;
      out_writeback_address <= wb_r ? wba_r : '0;
    end
  end

  always_comb begin
    status.out_busy = out_valid && out_stall;
    status.clear_done = (clr_r == IB'(SETS-1));
  end
endmodule

// ----- src/set_assoc_cache_tag_controller.sv -----
// Top level of the set-associative cache tag and replacement controller.
// Usage: requests arrive on in_valid/in_stall with in_address and in_op
// (0 read, 1 write). Each request yields one result on out_valid/out_stall:
// out_hit, out_set_index, out_way, out_writeback and out_writeback_address.
// A request passes through the READ, LOOKUP, PROMOTE, WRITE and OUT states
// before its result appears in the output register; the tag and counter
// memories are read and then written through a single port, so the
// controller handles one request at a time and accepts the next one once
// the result has been registered. The cfg port writes the replacement
// policy (index 0) and the index hash enable (index 1); the user must write
// them only while no request is in flight; the block does not enforce it.
// A synchronous active-low reset seeds the random generator and selects LRU
// with direct indexing; a clearing pass over all SETS sets (64 by default)
// then zeroes the valid, dirty, FIFO and counter state one set per cycle,
// with in_stall high. The tag memory is not cleared as only valid ways are
// used. While the receiver stalls, the result stays in the output register;
// a following request is processed up to the output stage and then waits
// there with in_stall high.
module set_assoc_cache_tag_controller import sactc_pkg::*; #(
  parameter int WAYS = DEF_WAYS,
  parameter int SETS = DEF_SETS,
  parameter int OFFSET_BITS = DEF_OFFSET_BITS,
  parameter int COUNTER_BITS = DEF_COUNTER_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [ADDR_W-1:0]     in_address,
  input  logic                  in_op,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_hit,
  output logic [SET_OUT_W-1:0]  out_set_index,
  output logic [WAY_OUT_W-1:0]  out_way,
  output logic                  out_writeback,
  output logic [ADDR_W-1:0]     out_writeback_address,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_index,
  input  logic [POLICY_W-1:0]   cfg_data
);
  `include "assert_macros.svh"

  logic [POLICY_W-1:0] policy_r;
  logic                hash_r;
  cmd_t                cmd;
  status_t             status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= POL_LRU;
      hash_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POLICY: policy_r <= cfg_data;
        REG_HASH:   hash_r <= cfg_data[0];
        default:    hash_r <= hash_r;
      endcase
    end
  end

  sactc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .status(status), .cmd(cmd)
  );

  sactc_dp #(
    .WAYS(WAYS), .SETS(SETS), .OFFSET_BITS(OFFSET_BITS), .COUNTER_BITS(COUNTER_BITS)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status),
    .in_address(in_address), .in_op(in_op), .policy(policy_r), .hash_en(hash_r),
    .out_valid(out_valid), .out_stall(out_stall), .out_hit(out_hit),
    .out_set_index(out_set_index), .out_way(out_way),
    .out_writeback(out_writeback), .out_writeback_address(out_writeback_address)
  );

  `SACTC_ASSERT_IMPL(a_hit_no_wb, out_valid && out_hit, !out_writeback, "hit with writeback")
  `SACTC_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, in_stall, "accepted while busy")
  `SACTC_ASSERT_IMPL(a_wb_addr_zero, out_valid && !out_writeback,
    out_writeback_address == '0, "writeback address without writeback")
endmodule
